### src/id3x_pkg.sv
// Shared types, constants and helpers for the ID3v2 text frame extractor.
package id3x_pkg;

  localparam int unsigned TextMaxChars = 63;
  localparam int unsigned TextWindow   = 128;

  localparam logic [1:0]  KIND_NONE = 2'd3;
  localparam logic [1:0]  KIND_DONE = 2'd3;
  localparam logic [31:0] ID_TIT2   = 32'h54495432;
  localparam logic [31:0] ID_TPE1   = 32'h54504531;
  localparam logic [31:0] ID_TALB   = 32'h54414C42;

  typedef enum logic [3:0] {
    PH_HDR  = 4'd0,
    PH_EXT  = 4'd1,
    PH_SKIP = 4'd2,
    PH_FHDR = 4'd3,
    PH_ENC  = 4'd4,
    PH_TEXT = 4'd5,
    PH_DONE = 4'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       eot;
    logic       st;
  } res_t;

  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] count;
  } res_grp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### src/id3v2_text_frame_extractor_unit.sv
// Result items pass through the registered four-entry result queue. Throughput: one
// byte per cycle while the queue holds under two items; a byte that causes two or
// three items holds input while the queue drains one item per cycle when not out_stall.
// Reset (rst, synchronous): parser expects a tag header, result queue empty.
// End of file rearms the parser for the next file.
module id3v2_text_frame_extractor_unit
  import id3x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_char,
  output logic       end_of_text,
  output logic       status
);

  res_grp_t grp;
  res_t     head;
  logic     room;

  assign in_stall = !room;

  id3x_parser u_parser (
    .clk(clk), .rst(rst), .accept(in_valid && room),
    .data_byte(data_byte), .end_of_file(end_of_file), .grp(grp)
  );

  id3x_res_queue u_queue (
    .clk(clk), .rst(rst), .grp(grp), .pop(out_valid && !out_stall),
    .room(room), .valid(out_valid), .head(head)
  );

  assign kind        = head.kind;
  assign out_char    = head.ch;
  assign end_of_text = head.eot;
  assign status      = head.st;

endmodule

### src/id3x_parser.sv
// Tag walker: per-byte state update that yields up to three result items.
module id3x_parser
  import id3x_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output res_grp_t   grp
);

  phase_t      phase, phase_next;
  logic [3:0]  part_pos, part_pos_next;
  logic [7:0]  major_version, major_version_next;
  logic        has_ext_header, has_ext_header_next;
  logic [27:0] tag_size, tag_size_next;
  logic [31:0] consumed, consumed_next;
  logic [31:0] size_accum, size_accum_next;
  logic [31:0] skip_left, skip_left_next;
  logic [31:0] frame_ident, frame_ident_next;
  logic [31:0] frame_len, frame_len_next;
  logic [1:0]  target_field, target_field_next;
  logic [7:0]  text_encoding, text_encoding_next;
  logic [7:0]  text_pos, text_pos_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        pair_offset, pair_offset_next;
  logic [5:0]  chars_out, chars_out_next;
  logic        run_open, run_open_next;

  always_comb begin
    logic        fin, fst, bnd, sk, putc, wide;
    logic [31:0] skn, cons1, ext_sz, wlen;
    logic [7:0]  c, win;
    logic [3:0]  p;
    fin = 1'b0; fst = 1'b0; bnd = 1'b0; sk = 1'b0; putc = 1'b0;
    skn = '0; cons1 = '0; ext_sz = '0; c = '0; p = part_pos;
    wide = (text_encoding == 8'h01) || (text_encoding == 8'h02);
    wlen = frame_len - 32'd1;
    win  = (wlen < 32'(TextWindow)) ? wlen[7:0] : 8'(TextWindow);
    grp  = '0;
    phase_next = phase; part_pos_next = part_pos; major_version_next = major_version;
    has_ext_header_next = has_ext_header; tag_size_next = tag_size;
    consumed_next = consumed; size_accum_next = size_accum; skip_left_next = skip_left;
    frame_ident_next = frame_ident; frame_len_next = frame_len;
    target_field_next = target_field; text_encoding_next = text_encoding;
    text_pos_next = text_pos; held_byte_next = held_byte; pair_offset_next = pair_offset;
    chars_out_next = chars_out; run_open_next = run_open;

    if (accept) begin
      unique case (phase)
        PH_HDR: begin
          part_pos_next = part_pos + 4'd1;
          if ((p == 4'd0 && data_byte != 8'h49) || (p == 4'd1 && data_byte != 8'h44) ||
              (p == 4'd2 && data_byte != 8'h33)) begin
            fin = 1'b1; fst = 1'b1;
          end else begin
            if (p == 4'd3) major_version_next = data_byte;
            else if (p == 4'd5) has_ext_header_next = data_byte[6];
            else if (p >= 4'd6) size_accum_next = {size_accum[24:0], data_byte[6:0]};
            if (p == 4'd9) begin
              tag_size_next = size_accum_next[27:0];
              consumed_next = '0;
              size_accum_next = '0;
              if (has_ext_header_next) begin
                phase_next = PH_EXT; part_pos_next = '0;
              end else begin
                bnd = 1'b1;
              end
            end
          end
        end
        PH_EXT: begin
          size_accum_next = (major_version == 8'd4) ? {size_accum[24:0], data_byte[6:0]}
                                                    : {size_accum[23:0], data_byte};
          part_pos_next = part_pos + 4'd1;
          if (part_pos_next == 4'd4) begin
            sk = 1'b1;
            if (major_version == 8'd4) begin
              consumed_next = sat_add(consumed, size_accum_next);
              skn = (size_accum_next >= 32'd4) ? size_accum_next - 32'd4 : '0;
            end else begin
              ext_sz = sat_add(32'd4, size_accum_next);
              consumed_next = sat_add(consumed, ext_sz);
              skn = size_accum_next;
            end
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_left - 32'd1;
          if (skip_left_next == '0) bnd = 1'b1;
        end
        PH_FHDR: begin
          part_pos_next = part_pos + 4'd1;
          if (p == 4'd0 && data_byte == 8'd0) begin
            fin = 1'b1;
          end else begin
            if (p < 4'd4) frame_ident_next = {frame_ident[23:0], data_byte};
            else if (p < 4'd8)
              size_accum_next = (major_version == 8'd4) ? {size_accum[24:0], data_byte[6:0]}
                                                        : {size_accum[23:0], data_byte};
            if (p == 4'd9) begin
              frame_len_next = size_accum;
              cons1 = sat_add(consumed, 32'd10);
              consumed_next = cons1;
              if (size_accum == '0 ||
                  ({1'b0, cons1} + {1'b0, size_accum}) > {5'b0, tag_size}) begin
                fin = 1'b1;
              end else begin
                if (frame_ident == ID_TIT2) target_field_next = 2'd0;
                else if (frame_ident == ID_TPE1) target_field_next = 2'd1;
                else if (frame_ident == ID_TALB) target_field_next = 2'd2;
                else target_field_next = KIND_NONE;
                consumed_next = sat_add(cons1, size_accum);
                if (target_field_next != KIND_NONE && size_accum > 32'd1) begin
                  phase_next = PH_ENC;
                end else begin
                  sk = 1'b1; skn = size_accum;
                end
              end
            end
          end
        end
        PH_ENC: begin
          text_encoding_next = data_byte;
          text_pos_next = '0; chars_out_next = '0;
          pair_offset_next = 1'b0; held_byte_next = '0;
          run_open_next = 1'b1;
          phase_next = PH_TEXT;
        end
        PH_TEXT: begin
          if (!wide) begin
            putc = 1'b1; c = data_byte;
          end else if (!text_pos[0]) begin
            held_byte_next = data_byte;
          end else if (text_pos == 8'd1 && held_byte == 8'hFF && data_byte == 8'hFE) begin
            pair_offset_next = 1'b0;
          end else if (text_pos == 8'd1 && held_byte == 8'hFE && data_byte == 8'hFF) begin
            pair_offset_next = 1'b1;
          end else begin
            if (text_pos == 8'd1) pair_offset_next = (text_encoding == 8'h02);
            putc = 1'b1;
            c = pair_offset_next ? data_byte : held_byte;
          end
          if (putc && run_open_next) begin
            if (c == 8'd0) begin
              grp.res[grp.count] = '{target_field, 8'd0, 1'b1, 1'b0};
              grp.count = grp.count + 2'd1;
              run_open_next = 1'b0;
            end else begin
              grp.res[grp.count] = '{target_field, c, 1'b0, 1'b0};
              grp.count = grp.count + 2'd1;
              chars_out_next = chars_out + 6'd1;
              if (chars_out_next >= 6'(TextMaxChars)) begin
                grp.res[grp.count] = '{target_field, 8'd0, 1'b1, 1'b0};
                grp.count = grp.count + 2'd1;
                run_open_next = 1'b0;
              end
            end
          end
          text_pos_next = text_pos + 8'd1;
          if (text_pos_next >= win) begin
            if (run_open_next) begin
              grp.res[grp.count] = '{target_field, 8'd0, 1'b1, 1'b0};
              grp.count = grp.count + 2'd1;
              run_open_next = 1'b0;
            end
            sk = 1'b1;
            skn = wlen - {24'd0, win};
          end
        end
        default: ;
      endcase

      if (sk) begin
        if (skn == '0) bnd = 1'b1;
        else begin
          phase_next = PH_SKIP; skip_left_next = skn;
        end
      end
      if (bnd) begin
        if (({1'b0, consumed_next} + 33'd10) <= {5'b0, tag_size_next}) begin
          phase_next = PH_FHDR; part_pos_next = '0;
          size_accum_next = '0; frame_ident_next = '0;
        end else begin
          fin = 1'b1; fst = 1'b0;
        end
      end
      if (fin) begin
        if (run_open_next) begin
          grp.res[grp.count] = '{target_field_next, 8'd0, 1'b1, 1'b0};
          grp.count = grp.count + 2'd1;
          run_open_next = 1'b0;
        end
        grp.res[grp.count] = '{KIND_DONE, 8'd0, 1'b0, fst};
        grp.count = grp.count + 2'd1;
        phase_next = PH_DONE;
      end
      if (end_of_file) begin
        if (phase_next != PH_DONE) begin
          if (run_open_next) begin
            grp.res[grp.count] = '{target_field_next, 8'd0, 1'b1, 1'b0};
            grp.count = grp.count + 2'd1;
          end
          grp.res[grp.count] = '{KIND_DONE, 8'd0, 1'b0,
                                 (phase_next == PH_HDR || phase_next == PH_EXT)};
          grp.count = grp.count + 2'd1;
        end
        // rearm for the next file
        phase_next = PH_HDR; part_pos_next = '0; major_version_next = '0;
        has_ext_header_next = 1'b0; tag_size_next = '0; consumed_next = '0;
        size_accum_next = '0; skip_left_next = '0; frame_ident_next = '0;
        frame_len_next = '0; target_field_next = KIND_NONE; text_encoding_next = '0;
        text_pos_next = '0; held_byte_next = '0; pair_offset_next = 1'b0;
        chars_out_next = '0; run_open_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; part_pos <= '0; major_version <= '0; has_ext_header <= 1'b0;
      tag_size <= '0; consumed <= '0; size_accum <= '0; skip_left <= '0;
      frame_ident <= '0; frame_len <= '0; target_field <= KIND_NONE;
      text_encoding <= '0; text_pos <= '0; held_byte <= '0; pair_offset <= 1'b0;
      chars_out <= '0; run_open <= 1'b0;
    end else begin
      phase <= phase_next; part_pos <= part_pos_next; major_version <= major_version_next;
      has_ext_header <= has_ext_header_next; tag_size <= tag_size_next;
      consumed <= consumed_next; size_accum <= size_accum_next;
      skip_left <= skip_left_next; frame_ident <= frame_ident_next;
      frame_len <= frame_len_next; target_field <= target_field_next;
      text_encoding <= text_encoding_next; text_pos <= text_pos_next;
      held_byte <= held_byte_next; pair_offset <= pair_offset_next;
      chars_out <= chars_out_next; run_open <= run_open_next;
    end
  end

endmodule

### src/id3x_res_queue.sv
// Four-entry result queue: takes up to three items a cycle, drains one per pop.
module id3x_res_queue
  import id3x_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  res_grp_t grp,
  input  logic     pop,
  output logic     room,
  output logic     valid,
  output res_t     head
);

  res_t       entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign room  = (count < 3'd2);
  assign valid = (count != 3'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < grp.count) entries[wr_ptr + 2'(i)] <= grp.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      wr_ptr <= wr_ptr + grp.count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, grp.count} - {2'b0, pop};
    end
  end

endmodule
